FILE: hw/rtl/utf8v_pkg.sv
// utf8v_pkg: shared constants, offset type and helpers for the UTF-8 stream checker.
// Depends on nothing; imported by utf8_stream_validator.
`timescale 1ns / 1ps
`default_nettype none

package utf8v_pkg;

  // Width of the byte offset counter (valid range 8..32).
  localparam int unsigned OFFSET_WIDTH = 16;
  localparam int unsigned REPORT_WIDTH = 16;

  typedef logic [OFFSET_WIDTH-1:0] offset_t;
  typedef logic [REPORT_WIDTH-1:0] report_t;
  typedef logic [7:0]              byte_t;

  localparam offset_t OFFSET_MAX = '1;

  // Byte masks and patterns.
  localparam byte_t MASK_C0   = 8'hc0;
  localparam byte_t MASK_E0   = 8'he0;
  localparam byte_t MASK_F0   = 8'hf0;
  localparam byte_t MASK_F8   = 8'hf8;
  localparam byte_t MASK_FE   = 8'hfe;
  localparam byte_t PAT_CONT  = 8'h80;
  localparam byte_t PAT_LEAD2 = 8'hc0;
  localparam byte_t PAT_LEAD3 = 8'he0;
  localparam byte_t PAT_LEAD4 = 8'hf0;
  localparam byte_t PAT_A0    = 8'ha0;
  localparam byte_t PAT_BE    = 8'hbe;

  // Lead and continuation values with extra range rules.
  localparam byte_t LEAD_E0   = 8'he0;
  localparam byte_t LEAD_ED   = 8'hed;
  localparam byte_t LEAD_EF   = 8'hef;
  localparam byte_t LEAD_F0   = 8'hf0;
  localparam byte_t LEAD_F4   = 8'hf4;
  localparam byte_t CONT_8F   = 8'h8f;
  localparam byte_t CONT_BF   = 8'hbf;

  // Low bits of an offset as reported on the result channel (zero-extended if narrower).
  function automatic report_t offset_report(input offset_t off);
    logic [31:0] wide;
    wide = 32'(off);
    return wide[REPORT_WIDTH-1:0];
  endfunction

  // Total length of a sequence from its lead byte: 2, 3 or 4.
  function automatic logic [2:0] seq_length(input byte_t lead);
    logic [2:0] len;
    if ((lead & MASK_E0) == PAT_LEAD2) len = 3'd2;
    else if ((lead & MASK_F0) == PAT_LEAD3) len = 3'd3;
    else len = 3'd4;
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/utf8_stream_validator.sv
// utf8_stream_validator: byte-serial UTF-8 checker with sticky first-error offset.
// Depends on utf8v_pkg for constants, the offset type and decode helpers.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_valid/in_ready/in_data_byte): one byte of a string per
//   transaction. A zero byte terminates the string.
//   Result channel (out_valid/out_ready/out_*): exactly one result transaction
//   per input byte, in order. out_string_done marks the terminator's result;
//   out_error_seen/out_error_offset give the verdict so far (offset of the lead
//   byte of the first bad sequence, 0 when clean).
// Timing
//   Two register stages: an input register and a result register. An accepted
//   byte waits in the input register until the result register is free and is
//   then decoded into it, so out_valid is up after that edge. Throughput is
//   one byte per cycle while results are not stalled; the decode between
//   the stages is a handful of byte compares plus the offset increment/saturate.
// Stalls
//   When out_ready is low the result register holds; the input register still
//   fills, so one more byte is taken, then in_ready drops until the result
//   moves. No transaction is dropped or repeated.
// Reset
//   rst_n (synchronous, active low) empties both stages and clears all
//   decoder state; a processed terminator clears the decoder state too.

module utf8_stream_validator
  import utf8v_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire byte_t in_data_byte,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       out_string_done,
  output logic       out_error_seen,
  output report_t    out_error_offset
);

  // ---------------------------------------------------------------- stages
  logic    s1_valid_r, s1_valid_nxt;
  byte_t   s1_byte_r;
  logic    out_valid_r, out_valid_nxt;
  logic    done_r, done_nxt;
  logic    err_out_r, err_out_nxt;
  report_t err_off_out_r, err_off_out_nxt;

  logic    out_free;   // result register can take a new value this cycle
  logic    s1_adv;     // stage 1 byte is decoded and moves to the result register
  logic    in_fire;

  // ---------------------------------------------------------------- decoder state
  offset_t    byte_offset_r, byte_offset_nxt;
  logic [1:0] pending_r, pending_nxt;
  byte_t      lead_r, lead_nxt;
  byte_t      second_r, second_nxt;
  offset_t    lead_off_r, lead_off_nxt;
  logic       err_r, err_nxt;
  offset_t    first_off_r, first_off_nxt;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  // Per-byte decode: one sequence step against the stored lead/second byte.
  logic [2:0] len;
  logic [2:0] pos;
  logic       cont_bad;
  logic       raise;
  offset_t    raise_off;
  byte_t      b;

  always_comb begin
    b               = s1_byte_r;
    len             = seq_length(lead_r);
    pos             = len - {1'b0, pending_r};
    raise           = 1'b0;
    raise_off       = byte_offset_r;
    cont_bad        = 1'b0;

    byte_offset_nxt = byte_offset_r;
    pending_nxt     = pending_r;
    lead_nxt        = lead_r;
    second_nxt      = second_r;
    lead_off_nxt    = lead_off_r;
    err_nxt         = err_r;
    first_off_nxt   = first_off_r;

    done_nxt        = done_r;
    err_out_nxt     = err_out_r;
    err_off_out_nxt = err_off_out_r;

    if (b == 8'h00) begin
      // Terminator: a sequence left open is an error at its lead byte.
      done_nxt        = 1'b1;
      err_out_nxt     = err_r || (pending_r != 2'd0);
      err_off_out_nxt = err_r ? offset_report(first_off_r)
                      : ((pending_r != 2'd0) ? offset_report(lead_off_r) : '0);
      byte_offset_nxt = '0;
      pending_nxt     = 2'd0;
      lead_nxt        = '0;
      second_nxt      = '0;
      lead_off_nxt    = '0;
      err_nxt         = 1'b0;
      first_off_nxt   = '0;
    end else begin
      if (!err_r) begin
        if (pending_r == 2'd0) begin
          if (!b[7]) begin
            // ASCII
          end else if ((b & MASK_E0) == PAT_LEAD2) begin
            if ((b & MASK_FE) == PAT_LEAD2) begin
              raise = 1'b1;  // overlong two-byte lead C0/C1
            end else begin
              lead_nxt     = b;
              second_nxt   = '0;
              pending_nxt  = 2'd1;
              lead_off_nxt = byte_offset_r;
            end
          end else if ((b & MASK_F0) == PAT_LEAD3) begin
            lead_nxt     = b;
            second_nxt   = '0;
            pending_nxt  = 2'd2;
            lead_off_nxt = byte_offset_r;
          end else if ((b & MASK_F8) == PAT_LEAD4) begin
            if (b > LEAD_F4) begin
              raise = 1'b1;
            end else begin
              lead_nxt     = b;
              second_nxt   = '0;
              pending_nxt  = 2'd3;
              lead_off_nxt = byte_offset_r;
            end
          end else begin
            raise = 1'b1;  // stray continuation or F8 and above
          end
        end else begin
          cont_bad  = (b & MASK_C0) != PAT_CONT;
          raise_off = lead_off_r;
          if (pos == 3'd1) begin
            if (lead_r == LEAD_E0 && (b & MASK_E0) == PAT_CONT) cont_bad = 1'b1;
            if (lead_r == LEAD_ED && (b & MASK_E0) == PAT_A0)   cont_bad = 1'b1;
            if (lead_r == LEAD_F0 && (b & MASK_F0) == PAT_CONT) cont_bad = 1'b1;
            if (lead_r == LEAD_F4 && b > CONT_8F)               cont_bad = 1'b1;
            second_nxt = b;
          end else if (pos == 3'd2 && len == 3'd3) begin
            // U+FFFE / U+FFFF
            if (lead_r == LEAD_EF && second_r == CONT_BF && (b & MASK_FE) == PAT_BE)
              cont_bad = 1'b1;
          end
          if (cont_bad) raise = 1'b1;
          else pending_nxt = pending_r - 2'd1;
        end

        if (raise) begin
          err_nxt       = 1'b1;
          first_off_nxt = raise_off;
          pending_nxt   = 2'd0;
        end
      end

      if (byte_offset_r != OFFSET_MAX) byte_offset_nxt = byte_offset_r + 1'b1;

      done_nxt        = 1'b0;
      err_out_nxt     = err_nxt;
      err_off_out_nxt = err_nxt ? offset_report(first_off_nxt) : '0;
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_free) out_valid_nxt = s1_valid_r;
    if (in_ready) s1_valid_nxt = in_valid;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      byte_offset_r <= '0;
      pending_r     <= 2'd0;
      lead_r        <= '0;
      second_r      <= '0;
      lead_off_r    <= '0;
      err_r         <= 1'b0;
      first_off_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        byte_offset_r <= byte_offset_nxt;
        pending_r     <= pending_nxt;
        lead_r        <= lead_nxt;
        second_r      <= second_nxt;
        lead_off_r    <= lead_off_nxt;
        err_r         <= err_nxt;
        first_off_r   <= first_off_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_data_byte;
    end
    if (s1_adv) begin
      done_r        <= done_nxt;
      err_out_r     <= err_out_nxt;
      err_off_out_r <= err_off_out_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_string_done  = done_r;
  assign out_error_seen   = err_out_r;
  assign out_error_offset = err_off_out_r;

endmodule

`default_nettype wire
